/* sv/u8s_pkg.sv */
// ----------------------------------------------------------------------------
// u8s_pkg
// Shared types, constants and helpers for the UTF-8 byte sanitizer.
// ----------------------------------------------------------------------------
package u8s_pkg;

    localparam int QDEPTH    = 8;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int QCW       = QAW + 1;
    localparam int MAX_BURST = 4;
    localparam int BURST_W   = $clog2(MAX_BURST + 1);

    localparam logic [7:0] QMARK     = 8'h3F;
    localparam logic [7:0] ASCII_TOP = 8'h80;
    localparam logic [7:0] LEAD2_LO  = 8'hC0;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF7;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       stream_end;
    } t_out_word;

    typedef struct packed {
        logic [BURST_W-1:0]          count;
        t_out_word [MAX_BURST-1:0]   words;
    } t_burst;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b >= LEAD2_LO && b <= LEAD2_HI) len = 3'd2;
        if (b >= LEAD3_LO && b <= LEAD3_HI) len = 3'd3;
        if (b >= LEAD4_LO && b <= LEAD4_HI) len = 3'd4;
        return len;
    endfunction

endpackage

/* sv/u8s_decode.sv */
// ----------------------------------------------------------------------------
// u8s_decode
// Sequence tracker: holds an open lead and its continuations and turns one
// registered input word into a burst of zero to four result words.
// ----------------------------------------------------------------------------
module u8s_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  u8s_pkg::t_in_word i_word,
    output u8s_pkg::t_burst   o_burst
);

    logic [7:0] r_held [3];
    logic [7:0] n_held [3];
    logic [1:0] r_cnt, n_cnt;
    logic [2:0] r_seq, n_seq;

    logic [7:0] b;
    logic       last;
    logic       idle;
    logic       is_cont;
    logic [2:0] s_len;
    logic       s_emit;
    logic [7:0] s_byte;
    logic [u8s_pkg::BURST_W-1:0] num;
    u8s_pkg::t_out_word [u8s_pkg::MAX_BURST-1:0] w;

    assign b       = i_word.in_byte;
    assign last    = i_word.in_last;
    assign idle    = (r_seq == 3'd0) || (r_cnt == 2'd0);
    assign is_cont = (b & u8s_pkg::CONT_MASK) == u8s_pkg::CONT_TAG;
    assign s_len   = u8s_pkg::lead_len(b);
    assign s_emit  = (b < u8s_pkg::ASCII_TOP) || (s_len == 3'd0) || last;
    assign s_byte  = (b < u8s_pkg::ASCII_TOP) ? b : u8s_pkg::QMARK;

    always_comb begin
        n_held = r_held;
        n_cnt  = r_cnt;
        n_seq  = r_seq;
        num    = '0;
        for (int k = 0; k < u8s_pkg::MAX_BURST; k++) begin
            w[k].out_byte = u8s_pkg::QMARK;
        end
        if (idle) begin
            n_cnt = 2'd0;
            n_seq = 3'd0;
            if (s_emit) begin
                w[0].out_byte = s_byte;
                num = u8s_pkg::BURST_W'(1);
            end else begin
                n_held[0] = b;
                n_cnt     = 2'd1;
                n_seq     = s_len;
            end
        end else if (is_cont) begin
            if (({1'b0, r_cnt} + 3'd1) >= r_seq) begin
                for (int k = 0; k < 3; k++) begin
                    w[k].out_byte = r_held[k];
                end
                w[r_cnt].out_byte = b;
                num   = u8s_pkg::BURST_W'(r_cnt) + u8s_pkg::BURST_W'(1);
                n_cnt = 2'd0;
                n_seq = 3'd0;
            end else if (last) begin
                num   = u8s_pkg::BURST_W'(r_cnt) + u8s_pkg::BURST_W'(1);
                n_cnt = 2'd0;
                n_seq = 3'd0;
            end else begin
                for (int k = 0; k < 3; k++) begin
                    if (r_cnt == 2'(k)) n_held[k] = b;
                end
                n_cnt = r_cnt + 2'd1;
            end
        end else begin
            num   = u8s_pkg::BURST_W'(r_cnt);
            n_cnt = 2'd0;
            n_seq = 3'd0;
            if (s_emit) begin
                w[r_cnt].out_byte = s_byte;
                num = u8s_pkg::BURST_W'(r_cnt) + u8s_pkg::BURST_W'(1);
            end else begin
                n_held[0] = b;
                n_cnt     = 2'd1;
                n_seq     = s_len;
            end
        end
        if (last) begin
            n_cnt = 2'd0;
            n_seq = 3'd0;
        end
        for (int k = 0; k < u8s_pkg::MAX_BURST; k++) begin
            w[k].run_end    = (u8s_pkg::BURST_W'(k) + u8s_pkg::BURST_W'(1)) == num;
            w[k].stream_end = w[k].run_end && last;
        end
        o_burst.count = num;
        o_burst.words = w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_seq <= 3'd0;
        end else if (i_adv) begin
            r_cnt <= n_cnt;
            r_seq <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_held <= n_held;
        end
    end

`ifndef NO_ASSERTIONS
    a_last_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && last |=> (r_cnt == 2'd0) && (r_seq == 3'd0))
        else $error("state not cleared after final word");
    a_cnt_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != 3'd0) |-> ({1'b0, r_cnt} < r_seq))
        else $error("held count reached sequence length");
    a_burst_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv |-> (num <= u8s_pkg::BURST_W'(u8s_pkg::MAX_BURST)))
        else $error("burst larger than four words");
`endif

endmodule

/* sv/u8s_queue.sv */
// ----------------------------------------------------------------------------
// u8s_queue
// Result queue: takes a burst of up to four words per cycle when it has room,
// hands out one word per cycle to the output channel unless it stalls.
// ----------------------------------------------------------------------------
module u8s_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  u8s_pkg::t_burst    i_burst,
    output logic               o_room,
    output logic               o_out_valid,
    output u8s_pkg::t_out_word o_out,
    input  logic               i_out_stall
);

    u8s_pkg::t_out_word r_mem [u8s_pkg::QDEPTH];
    logic [u8s_pkg::QAW-1:0] r_wr, n_wr;
    logic [u8s_pkg::QAW-1:0] r_rd, n_rd;
    logic [u8s_pkg::QCW-1:0] r_count, n_count;
    logic                    pop;
    logic [u8s_pkg::QCW-1:0] add;

    assign o_out_valid = r_count != '0;
    assign o_out       = r_mem[r_rd];
    assign pop         = o_out_valid && !i_out_stall;
    assign o_room      = r_count <= u8s_pkg::QCW'(u8s_pkg::QDEPTH - u8s_pkg::MAX_BURST);
    assign add         = i_push ? u8s_pkg::QCW'(i_burst.count) : '0;

    always_comb begin
        n_wr    = r_wr + u8s_pkg::QAW'(add);
        n_rd    = pop ? r_rd + u8s_pkg::QAW'(1) : r_rd;
        n_count = r_count + add - (pop ? u8s_pkg::QCW'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int k = 0; k < u8s_pkg::MAX_BURST; k++) begin
                if (u8s_pkg::BURST_W'(k) < i_burst.count) begin
                    r_mem[r_wr + u8s_pkg::QAW'(k)] <= i_burst.words[k];
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= u8s_pkg::QCW'(u8s_pkg::QDEPTH))
        else $error("queue count above depth");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room)
        else $error("burst pushed without room");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != u8s_pkg::QCW'(u8s_pkg::QDEPTH)) |->
            (u8s_pkg::QAW'(r_wr - r_rd) == u8s_pkg::QAW'(r_count)))
        else $error("pointers disagree with count");
`endif

endmodule

/* sv/utf8_byte_sanitizer.sv */
// ----------------------------------------------------------------------------
// utf8_byte_sanitizer
// Passes a byte stream through, replacing bytes of broken UTF-8 sequences
// with '?'.
//
// Input channel: i_in_valid / o_in_stall carry one word (byte plus end mark).
// Output channel: o_out_valid / i_out_stall carry one word (byte, run_end,
// stream_end). One input word yields zero to four output words; over a
// whole stream the counts match.
// An accepted word lands in the input register, is decoded into the result
// queue once the queue has room, and then reaches the output. Bytes of an
// open sequence wait until the sequence completes or breaks.
// Throughput: one input word per cycle while o_in_stall is low, one output
// word per cycle while i_out_stall is low. The input register advances
// whenever the 8-entry queue has room for four; o_in_stall rises only if not.
// Reset clears the sequence state and empties the queue. While the
// receiver stalls, the output word holds and the queue fills until the
// input side stalls in turn.
// ----------------------------------------------------------------------------
module utf8_byte_sanitizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  u8s_pkg::t_in_word  i_in,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output u8s_pkg::t_out_word o_out,
    input  logic               i_out_stall
);

    logic              r_in_valid;
    u8s_pkg::t_in_word r_in;
    logic              room;
    logic              adv;
    logic              take;
    u8s_pkg::t_burst   burst;

    assign adv        = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign take       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in <= i_in;
        end
    end

    u8s_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_word  (r_in),
        .o_burst (burst)
    );

    u8s_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (adv),
        .i_burst     (burst),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

/* dv/tb_utf8_byte_sanitizer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_byte_sanitizer
// Self-checking bench for the UTF-8 byte sanitizer. A short directed stream
// covers plain bytes, complete and broken sequences, stray bytes and early
// stream ends. A long random stream follows, mostly well-formed sequences
// mixed with noise and cut-off sequences. Both sides idle at random. Every
// output word is compared against a behavioral copy of the sanitizer that
// tracks the held lead and continuation bytes.
// ----------------------------------------------------------------------------
module tb_utf8_byte_sanitizer;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 345;

    class sanitized_stream;
        logic [7:0]           held [3];
        int unsigned          held_cnt;
        int unsigned          seq_len;
        u8s_pkg::t_out_word   due_words [$];
        int                   errors;

        function new();
            held_cnt = 0;
            seq_len  = 0;
            errors   = 0;
        endfunction

        function void add_word(ref u8s_pkg::t_out_word q [$], input u8s_pkg::t_out_word w);
            q = {q, w};
        endfunction

        function int unsigned lead_span(logic [7:0] b);
            if (b >= u8s_pkg::LEAD2_LO && b <= u8s_pkg::LEAD2_HI) return 2;
            if (b >= u8s_pkg::LEAD3_LO && b <= u8s_pkg::LEAD3_HI) return 3;
            if (b >= u8s_pkg::LEAD4_LO && b <= u8s_pkg::LEAD4_HI) return 4;
            return 0;
        endfunction

        function u8s_pkg::t_out_word plain(logic [7:0] b);
            u8s_pkg::t_out_word w;
            w          = '0;
            w.out_byte = b;
            return w;
        endfunction

        function void judge_start(logic [7:0] b, bit fin,
                                  ref u8s_pkg::t_out_word step_words [$]);
            int unsigned span;
            span = lead_span(b);
            if (b < u8s_pkg::ASCII_TOP) begin
                add_word(step_words, plain(b));
            end else if (span == 0 || fin) begin
                add_word(step_words, plain(u8s_pkg::QMARK));
            end else begin
                held[0]  = b;
                held_cnt = 1;
                seq_len  = span;
            end
        endfunction

        function void note_raw(u8s_pkg::t_in_word w);
            u8s_pkg::t_out_word step_words [$];
            logic [7:0]         b;
            bit                 fin;
            int unsigned        i;
            int                 n;
            b   = w.in_byte;
            fin = w.in_last;
            if (seq_len == 0 || held_cnt == 0) begin
                held_cnt = 0;
                seq_len  = 0;
                judge_start(b, fin, step_words);
            end else if ((b & u8s_pkg::CONT_MASK) == u8s_pkg::CONT_TAG) begin
                if (held_cnt + 1 >= seq_len) begin
                    for (i = 0; i < held_cnt; i++) add_word(step_words, plain(held[i]));
                    add_word(step_words, plain(b));
                    held_cnt = 0;
                    seq_len  = 0;
                end else if (fin) begin
                    for (i = 0; i <= held_cnt; i++)
                        add_word(step_words, plain(u8s_pkg::QMARK));
                    held_cnt = 0;
                    seq_len  = 0;
                end else begin
                    held[held_cnt] = b;
                    held_cnt++;
                end
            end else begin
                for (i = 0; i < held_cnt; i++) add_word(step_words, plain(u8s_pkg::QMARK));
                held_cnt = 0;
                seq_len  = 0;
                judge_start(b, fin, step_words);
            end
            if (fin) begin
                held_cnt = 0;
                seq_len  = 0;
            end
            n = step_words.size();
            if (n > 0) begin
                step_words[n-1].run_end    = 1'b1;
                step_words[n-1].stream_end = fin;
            end
            foreach (step_words[k]) add_word(due_words, step_words[k]);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_clean(u8s_pkg::t_out_word got);
            u8s_pkg::t_out_word want;
            if (due_words.size() == 0) begin
                report($sformatf("unexpected word byte=%h run_end=%b stream_end=%b",
                                 got.out_byte, got.run_end, got.stream_end));
                return;
            end
            want = due_words.pop_front();
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
            if (got.run_end !== want.run_end)
                report($sformatf("run_end %b, want %b (byte %h)",
                                 got.run_end, want.run_end, want.out_byte));
            if (got.stream_end !== want.stream_end)
                report($sformatf("stream_end %b, want %b (byte %h)",
                                 got.stream_end, want.stream_end, want.out_byte));
        endtask
    endclass

    logic               i_clk     = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    u8s_pkg::t_in_word  in_word   = '0;
    logic               out_stall = 1'b1;
    logic               o_in_stall;
    logic               o_out_valid;
    u8s_pkg::t_out_word o_out;
    bit                 calm      = 1'b0;

    sanitized_stream   sb = new();
    u8s_pkg::t_in_word stim [$];

    utf8_byte_sanitizer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in        (in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (out_stall)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task queue_raw(logic [7:0] b, bit fin);
        u8s_pkg::t_in_word w;
        w.in_byte = b;
        w.in_last = fin;
        stim = {stim, w};
    endtask

    function logic [7:0] cont_byte();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    function logic [7:0] lead_byte(int unsigned span);
        case (span)
            2:       return 8'($urandom_range(u8s_pkg::LEAD2_LO, u8s_pkg::LEAD2_HI));
            3:       return 8'($urandom_range(u8s_pkg::LEAD3_LO, u8s_pkg::LEAD3_HI));
            default: return 8'($urandom_range(u8s_pkg::LEAD4_LO, u8s_pkg::LEAD4_HI));
        endcase
    endfunction

    task build_random(int unsigned total);
        int unsigned pick;
        int unsigned span;
        int unsigned conts;
        while (stim.size() < total) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3: queue_raw(8'($urandom_range(0, 127)), 1'b0);
                4, 5, 6: begin
                    span = $urandom_range(2, 4);
                    queue_raw(lead_byte(span), 1'b0);
                    repeat (span - 1) queue_raw(cont_byte(), 1'b0);
                end
                7: begin
                    span  = $urandom_range(2, 4);
                    conts = $urandom_range(0, span - 2);
                    queue_raw(lead_byte(span), 1'b0);
                    repeat (conts) queue_raw(cont_byte(), 1'b0);
                end
                8:       queue_raw(8'($urandom_range(0, 255)), 1'b0);
                default: queue_raw(8'($urandom_range(128, 255)), 1'b0);
            endcase
            if ($urandom_range(0, 9) == 0) stim[stim.size()-1].in_last = 1'b1;
        end
        stim[stim.size()-1].in_last = 1'b1;
    endtask

    task send_raw(u8s_pkg::t_in_word w);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_raw(w);
    endtask

    initial begin
        int unsigned gap;
        wait (rst_n === 1'b1);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_clean(o_out);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) quiet = 0;
            else quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int unsigned k;
        queue_raw(8'h00, 1'b0);
        queue_raw(8'h7F, 1'b0);
        queue_raw(8'h80, 1'b0);
        queue_raw(8'hFF, 1'b0);
        queue_raw(8'hF8, 1'b0);
        queue_raw(8'hC0, 1'b0);
        queue_raw(8'hBF, 1'b0);
        queue_raw(8'hE0, 1'b0);
        queue_raw(8'h80, 1'b0);
        queue_raw(8'hBF, 1'b0);
        queue_raw(8'hF7, 1'b0);
        queue_raw(8'hBF, 1'b0);
        queue_raw(8'h80, 1'b0);
        queue_raw(8'h80, 1'b0);
        queue_raw(8'hDF, 1'b0);
        queue_raw(8'h41, 1'b0);
        queue_raw(8'hEF, 1'b0);
        queue_raw(8'h80, 1'b0);
        queue_raw(8'hC5, 1'b0);
        queue_raw(8'h80, 1'b1);
        queue_raw(8'hF0, 1'b0);
        queue_raw(8'h80, 1'b0);
        queue_raw(8'h80, 1'b1);
        queue_raw(8'hE5, 1'b1);
        queue_raw(8'h41, 1'b1);
        build_random(stim.size() + RANDOM_ITEMS);

        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        for (k = 0; k < stim.size(); k++) begin
            calm = ((k / 40) % 3) == 2;
            send_raw(stim[k]);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (sb.due_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.due_words.size() != 0)
            sb.report($sformatf("%0d words never arrived", sb.due_words.size()));
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
